@@ rtl/psbd_pkg.sv @@
// ----------------------------------------------------------------------------
// psbd_pkg - shared definitions for the pot smoothing and button debounce block
// Widths, register indexes, reset values and the per-button status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psbd_pkg;

    // Field widths
    localparam int ADC_W      = 12;
    localparam int POT_W      = 8;
    localparam int TIME_W     = 32;
    localparam int THRESH_W   = 8;
    localparam int DEBOUNCE_W = 16;
    localparam int NUM_BTN    = 3;

    // Smoothing: new = (old * 7 + raw) >> 3, computed in 11 bits
    localparam int SMOOTH_SHIFT = 3;
    localparam int SMOOTH_W     = POT_W + SMOOTH_SHIFT;

    // Stream payload widths (packed, padded to whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DEBOUNCE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_POT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 1'd1;

    localparam logic [THRESH_W-1:0]   THRESH_RESET   = 8'd2;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd30;

    // Status of one debounced button for the current item
    typedef struct packed {
        logic press;
        logic release_evt;
        logic level;
    } t_btn_status;

endpackage

@@ rtl/psbd_button.sv @@
// ----------------------------------------------------------------------------
// psbd_button - debounce channel for one button
// Holds the debounced level and the time of the last accepted change; a new
// level is taken when it differs and the wrapped elapsed time exceeds the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psbd_button (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic                                i_level,
    input  logic [psbd_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [psbd_pkg::DEBOUNCE_W-1:0]     i_debounce_ms,
    output psbd_pkg::t_btn_status               o_status
);

    logic                          r_level;
    logic [psbd_pkg::TIME_W-1:0]   r_last_time;
    logic [psbd_pkg::TIME_W-1:0]   elapsed;
    logic                          accept;

    // Wrapped elapsed time since the last accepted change
    assign elapsed = i_now_ms - r_last_time;
    assign accept  = (i_level != r_level) &&
                     (elapsed > {{(psbd_pkg::TIME_W-psbd_pkg::DEBOUNCE_W){1'b0}}, i_debounce_ms});

    // Report events and the level after this item
    always_comb begin
        o_status.press       = accept && i_level;
        o_status.release_evt = accept && !i_level;
        o_status.level       = accept ? i_level : r_level;
    end

    // Take the new level when the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= 1'b0;
            r_last_time <= '0;
        end else if (i_advance && accept) begin
            r_level     <= i_level;
            r_last_time <= i_now_ms;
        end
    end

endmodule

@@ rtl/pot_smoothing_button_debounce.sv @@
// ----------------------------------------------------------------------------
// pot_smoothing_button_debounce - pot smoothing and three-button debounce
// An item accepted at a clock edge loads the input register; it moves into the
// result register when that register is free or its result is being taken, and
// is then offered until taken. Throughput: one item per cycle while the output
// is taken; the input register lets the next item in while a result waits.
// Reset (synchronous, active low) clears the smoothed value, button levels and
// times, and loads the register defaults (threshold 2, debounce 30 ms).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pot_smoothing_button_debounce (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [11:0] adc_sample, [12] select_level, [13] back_level, [14] aux_level,
    // [46:15] now_ms, [47] zero
    input  logic [psbd_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // Result items
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] pot_value, [8] pot_changed, [11:9] press_events,
    // [14:12] release_events, [17:15] button_levels, [23:18] zero
    output logic [psbd_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // Configuration writes
    input  logic                                i_cfg_we,
    input  logic [psbd_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [psbd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int POT_W = psbd_pkg::POT_W;
    localparam int NB    = psbd_pkg::NUM_BTN;
    localparam int SW    = psbd_pkg::SMOOTH_W;

    // Configuration registers
    logic [psbd_pkg::THRESH_W-1:0]   r_threshold;
    logic [psbd_pkg::DEBOUNCE_W-1:0] r_debounce;

    // Input register
    logic                            r_in_vld;
    logic [POT_W-1:0]                r_in_raw;
    logic [NB-1:0]                   r_in_lvl;
    logic [psbd_pkg::TIME_W-1:0]     r_in_now;

    // Result register
    logic                            r_out_vld;
    logic [POT_W-1:0]                r_out_pot;
    logic                            r_out_changed;
    logic [NB-1:0]                   r_out_press;
    logic [NB-1:0]                   r_out_release;
    logic [NB-1:0]                   r_out_levels;

    // Smoothing state
    logic [POT_W-1:0]                r_pot;
    logic [POT_W-1:0]                n_pot;
    logic [SW-1:0]                   sum;
    logic [POT_W-1:0]                diff;
    logic                            changed;

    logic                            advance;
    psbd_pkg::t_btn_status           btn_status [NB];
    logic [NB-1:0]                   press;
    logic [NB-1:0]                   release_evt;
    logic [NB-1:0]                   levels;

    // Handshake: move the held item on when the result register is free
    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= psbd_pkg::THRESH_RESET;
            r_debounce  <= psbd_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                psbd_pkg::CFG_POT_THRESHOLD: r_threshold <= i_cfg_wdata[psbd_pkg::THRESH_W-1:0];
                psbd_pkg::CFG_DEBOUNCE_MS:   r_debounce  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the input item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_raw <= i_s_axis_tdata[psbd_pkg::ADC_W-1 -: POT_W];
            r_in_lvl <= i_s_axis_tdata[psbd_pkg::ADC_W +: NB];
            r_in_now <= i_s_axis_tdata[psbd_pkg::ADC_W+NB +: psbd_pkg::TIME_W];
        end
    end

    // Smooth: (old * 7 + raw) >> 3, with old * 7 as old * 8 - old
    always_comb begin
        sum   = {r_pot, {psbd_pkg::SMOOTH_SHIFT{1'b0}}} - {{psbd_pkg::SMOOTH_SHIFT{1'b0}}, r_pot}
              + {{psbd_pkg::SMOOTH_SHIFT{1'b0}}, r_in_raw};
        n_pot = sum[SW-1:psbd_pkg::SMOOTH_SHIFT];
        diff  = (n_pot >= r_pot) ? (n_pot - r_pot) : (r_pot - n_pot);
        changed = diff > r_threshold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot <= '0;
        end else if (advance) begin
            r_pot <= n_pot;
        end
    end

    // Debounce each button
    for (genvar g = 0; g < NB; g++) begin : g_btn
        psbd_button u_button (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_advance     (advance),
            .i_level       (r_in_lvl[g]),
            .i_now_ms      (r_in_now),
            .i_debounce_ms (r_debounce),
            .o_status      (btn_status[g])
        );
        assign press[g]       = btn_status[g].press;
        assign release_evt[g] = btn_status[g].release_evt;
        assign levels[g]      = btn_status[g].level;
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pot     <= n_pot;
            r_out_changed <= changed;
            r_out_press   <= press;
            r_out_release <= release_evt;
            r_out_levels  <= levels;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(psbd_pkg::M_TDATA_W-POT_W-1-3*NB){1'b0}},
                              r_out_levels, r_out_release, r_out_press,
                              r_out_changed, r_out_pot};

endmodule
